// ===== src/stbs_pkg.sv =====
package stbs_pkg;

   localparam int KEY_W      = 32;
   localparam int POS_W      = 5;
   localparam int COUNT_W    = 6;
   localparam int BOUND_W    = 7;
   localparam int COUNT_RST  = 32;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic wr_en;
      logic in_probe;
      logic res_capture;
      logic out_load;
      logic out_sel_hold;
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
      logic more;
   } ctrl_status_type;

endpackage

// ===== src/stbs_req_if.sv =====
interface stbs_req_if import stbs_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [POS_W-1:0]        entry_position;
   logic signed [KEY_W-1:0] key_value;

   modport source (output valid, cmd, entry_position, key_value, input ready);
   modport sink   (input valid, cmd, entry_position, key_value, output ready);
endinterface

// ===== src/stbs_rsp_if.sv =====
interface stbs_rsp_if import stbs_pkg::*;;
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] match_position;

   modport source (output valid, found, match_position, input ready);
   modport sink   (input valid, found, match_position, output ready);
endinterface

// ===== src/sorted_table_binary_search_core.sv =====
// Sorted-table binary search.
// req_chan (sink): valid/ready beat with cmd, entry_position, key_value.
//   cmd 0 stores key_value at entry_position (no response beat); cmd 1
//   searches the first entries_in_use positions (clamped to TABLE_DEPTH).
// rsp_chan (source): one beat per search with found and match_position
//   (match_position is 0 on a miss).
// csr_wr_en/csr_wr_data load entries_in_use; write only while idle.
// Search sequence: accept the request, then probe the registered table read,
//   ceil(log2(n+1)) probes at most (6 for 32 entries); after the last probe
//   the response is loaded into the output register, or parked if it is busy.
//   An empty table answers without probing.
// Flow: one item at a time; req ready is high only between items.
// Reset (synchronous, active high) clears control state and sets
//   entries_in_use to 32; the table contents are undefined until written.
// Stall: a waiting response beat holds in the output register; a search
//   that finishes meanwhile parks its result and ready stays low until the
//   output register frees.
module sorted_table_binary_search_core import stbs_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   stbs_req_if.sink           req_chan,
   stbs_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_entry_position (req_chan.entry_position),
      .req_key_value      (req_chan.key_value),
      .cmd                (cmd),
      .status             (status),
      .rsp_found          (rsp_chan.found),
      .rsp_match_position (rsp_chan.match_position)
   );

endmodule

// ===== src/stbs_datapath.sv =====
module stbs_datapath import stbs_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [COUNT_W-1:0]      csr_wr_data,
   input  logic [POS_W-1:0]        req_entry_position,
   input  logic signed [KEY_W-1:0] req_key_value,
   input  ctrl_cmd_type            cmd,
   output ctrl_status_type         status,
   output logic                    rsp_found,
   output logic [POS_W-1:0]        rsp_match_position
);

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int RD_EXT_W  = (IDX_W > BOUND_W) ? IDX_W : BOUND_W;
   localparam int WR_EXT_W  = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam int COUNT_CAP = (TABLE_DEPTH < 63) ? TABLE_DEPTH : 63;

   logic [KEY_W-1:0]          table_mem [TABLE_DEPTH];
   logic signed [KEY_W-1:0]   rd_data_ff;
   logic [COUNT_W-1:0]        entries_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic signed [BOUND_W-1:0] low_ff, high_ff, mid_ff;
   logic                      res_found_ff;
   logic [POS_W-1:0]          res_pos_ff;
   logic                      out_found_ff;
   logic [POS_W-1:0]          out_pos_ff;

   logic signed [BOUND_W-1:0] count_w, high0_w, mid0_w;
   logic signed [BOUND_W-1:0] new_low_w, new_high_w, new_mid_w, rd_mid_w;
   logic signed [BOUND_W:0]   sum_w;
   logic                      eq_w, lt_w, more_w;
   logic [RD_EXT_W-1:0]       rd_ext_w;
   logic [IDX_W-1:0]          rd_addr_w;
   logic [WR_EXT_W-1:0]       wr_ext_w;
   logic [IDX_W-1:0]          wr_addr_w;
   logic                      wr_ok_w;
   logic                      live_found_w;
   logic [POS_W-1:0]          live_pos_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= COUNT_W'(COUNT_RST);
      end else if (csr_wr_en) begin
         entries_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (32'(entries_ff) > COUNT_CAP) begin
         count_w = BOUND_W'(COUNT_CAP);
      end else begin
         count_w = BOUND_W'(entries_ff);
      end
      high0_w = count_w - BOUND_W'(1);
      mid0_w  = high0_w >>> 1;

      eq_w = (key_ff == rd_data_ff);
      lt_w = (key_ff < rd_data_ff);
      if (lt_w) begin
         new_low_w  = low_ff;
         new_high_w = mid_ff - BOUND_W'(1);
      end else begin
         new_low_w  = mid_ff + BOUND_W'(1);
         new_high_w = high_ff;
      end
      more_w    = (new_low_w <= new_high_w);
      sum_w     = {new_low_w[BOUND_W-1], new_low_w} + {new_high_w[BOUND_W-1], new_high_w};
      new_mid_w = BOUND_W'(sum_w >>> 1);

      rd_mid_w  = cmd.start ? mid0_w : new_mid_w;
      rd_ext_w  = RD_EXT_W'($unsigned(rd_mid_w));
      rd_addr_w = rd_ext_w[IDX_W-1:0];

      wr_ext_w  = WR_EXT_W'(req_entry_position);
      wr_addr_w = wr_ext_w[IDX_W-1:0];
      wr_ok_w   = (32'(req_entry_position) < TABLE_DEPTH);

      live_found_w = cmd.in_probe & eq_w;
      live_pos_w   = live_found_w ? mid_ff[POS_W-1:0] : '0;
   end

   assign status.empty = (count_w == '0);
   assign status.hit   = eq_w;
   assign status.more  = more_w;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok_w) begin
         table_mem[wr_addr_w] <= req_key_value;
      end
      rd_data_ff <= table_mem[rd_addr_w];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff  <= req_key_value;
         low_ff  <= '0;
         high_ff <= high0_w;
         mid_ff  <= mid0_w;
      end else if (cmd.step) begin
         low_ff  <= new_low_w;
         high_ff <= new_high_w;
         mid_ff  <= new_mid_w;
      end
      if (cmd.res_capture) begin
         res_found_ff <= live_found_w;
         res_pos_ff   <= live_pos_w;
      end
      if (cmd.out_load) begin
         out_found_ff <= cmd.out_sel_hold ? res_found_ff : live_found_w;
         out_pos_ff   <= cmd.out_sel_hold ? res_pos_ff : live_pos_w;
      end
   end

   assign rsp_found          = out_found_ff;
   assign rsp_match_position = out_pos_ff;

endmodule

// ===== src/stbs_ctrl.sv =====
module stbs_ctrl import stbs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_cmd,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free_w, finish_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      finish_w   = 1'b0;
      out_free_w = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_SEARCH) begin
                  if (status.empty) begin
                     finish_w = 1'b1;
                  end else begin
                     cmd.start = 1'b1;
                     state_in  = ST_PROBE;
                  end
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            cmd.in_probe = 1'b1;
            cmd.step     = 1'b1;
            if (status.hit || !status.more) begin
               finish_w = 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free_w) begin
               cmd.out_load     = 1'b1;
               cmd.out_sel_hold = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish_w) begin
         if (out_free_w) begin
            cmd.out_load = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            cmd.res_capture = 1'b1;
            state_in        = ST_HOLD;
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat overwritten while stalled");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_cmd == CMD_WRITE)
         |=> (state_ff == ST_IDLE && !(rsp_valid_ff && !$past(rsp_valid_ff))))
      else $error("write beat produced a result");

   a_hold_only_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_HOLD && state_in == ST_HOLD) |-> (rsp_valid_ff && !rsp_ready))
      else $error("held result while output was free");

   a_hold_keeps_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("hold state with empty output register");
`endif

endmodule

// ===== tb/sorted_table_binary_search_core_test.sv =====
`timescale 1ns / 100ps

module sorted_table_binary_search_core_test;
   import stbs_pkg::*;

   localparam int DEPTH   = 32;
   localparam int MAX_GAP = 6;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } lookup_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   stbs_req_if req_chan ();
   stbs_rsp_if rsp_chan ();

   sorted_table_binary_search_core #(.TABLE_DEPTH(DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // shadow of the table and of the clamped entry count
   logic signed [KEY_W-1:0] key_shadow [DEPTH];
   int         search_span = DEPTH;
   lookup_type pending_lookups [$];
   int         mismatches = 0;
   bit         no_gaps = 1'b0;

   function automatic lookup_type bisect(input logic signed [KEY_W-1:0] key);
      lookup_type r;
      int lo;
      int hi;
      int mid;
      r = '0;
      lo = 0;
      hi = search_span - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key == key_shadow[mid]) begin
            r.found = 1'b1;
            r.position = mid[POS_W-1:0];
            return r;
         end
         if (key < key_shadow[mid])
            hi = mid - 1;
         else
            lo = mid + 1;
      end
      return r;
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_item(input cmd_type c, input logic [POS_W-1:0] p,
                            input logic signed [KEY_W-1:0] k);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.cmd            <= c;
      req_chan.entry_position <= p;
      req_chan.key_value      <= k;
      do @(posedge clock); while (!req_chan.ready);
      if (c == CMD_WRITE)
         key_shadow[p] = k;
      else
         pending_lookups.push_back(bisect(k));
   endtask

   task automatic store_key(input int p, input logic signed [KEY_W-1:0] k);
      send_item(CMD_WRITE, p[POS_W-1:0], k);
   endtask

   task automatic lookup_key(input logic signed [KEY_W-1:0] k);
      logic [POS_W-1:0] junk;
      junk = POS_W'($urandom);
      send_item(CMD_SEARCH, junk, k);
   endtask

   // drop valid and wait out all responses
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_span(input int value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[COUNT_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      search_span = (value > DEPTH) ? DEPTH : value;
   endtask

   task automatic load_sorted_table(input bit wide);
      logic signed [KEY_W-1:0] keys [DEPTH];
      logic signed [KEY_W-1:0] tmp;
      int j;
      if (wide) begin
         for (int i = 0; i < DEPTH; i++) keys[i] = $urandom;
         for (int i = 1; i < DEPTH; i++) begin
            tmp = keys[i];
            j = i - 1;
            while (j >= 0 && keys[j] > tmp) begin
               keys[j + 1] = keys[j];
               j--;
            end
            keys[j + 1] = tmp;
         end
      end else begin
         // narrow steps, duplicates included
         keys[0] = $signed($urandom) >>> 2;
         for (int i = 1; i < DEPTH; i++) keys[i] = keys[i - 1] + $urandom_range(0, 3);
      end
      for (int i = 0; i < DEPTH; i++) store_key(i, keys[i]);
   endtask

   task automatic test_empty_table();
      set_span(0);
      lookup_key(0);
      lookup_key(KEY_MIN);
      lookup_key(KEY_MAX);
   endtask

   task automatic test_sorted_extremes();
      set_span(DEPTH);
      for (int i = 0; i < DEPTH; i++)
         store_key(i, (i == 0) ? KEY_MIN : (i == DEPTH - 1) ? KEY_MAX : (i - 15) * 1000);
      lookup_key(KEY_MIN);
      lookup_key(KEY_MAX);
      lookup_key(0);
      lookup_key(500);
      lookup_key(KEY_MIN + 1);
      lookup_key(KEY_MAX - 1);
      lookup_key(key_shadow[7]);
      lookup_key(key_shadow[24]);
   endtask

   task automatic test_entry_counts();
      set_span(1);
      lookup_key(KEY_MIN);
      lookup_key(0);
      set_span(2);
      lookup_key(key_shadow[1]);
      lookup_key(key_shadow[0]);
      set_span(33);
      lookup_key(KEY_MAX);
      set_span(63);
      lookup_key(KEY_MAX);
      lookup_key(key_shadow[16]);
      set_span(17);
      lookup_key(key_shadow[16]);
      lookup_key(key_shadow[20]);
   endtask

   task automatic test_unsorted_keys();
      set_span(DEPTH);
      store_key(15, KEY_MAX);
      lookup_key(KEY_MAX);
      store_key(8, KEY_MIN);
      lookup_key(KEY_MIN);
      lookup_key(key_shadow[23]);
   endtask

   task automatic test_random_lookups();
      int sent;
      int r;
      int idx;
      logic signed [KEY_W-1:0] k;
      sent = 0;
      while (sent < 900) begin
         r = $urandom_range(0, 9);
         if (r < 4)
            set_span(DEPTH);
         else if (r == 4)
            set_span(0);
         else if (r == 5)
            set_span(63);
         else
            set_span($urandom_range(1, 63));
         no_gaps = ($urandom_range(0, 4) == 0);
         load_sorted_table(1'($urandom_range(0, 1)));
         sent += DEPTH;
         repeat (70) begin
            idx = (search_span > 0) ? $urandom_range(0, search_span - 1)
                                    : $urandom_range(0, DEPTH - 1);
            r = $urandom_range(0, 99);
            if (r < 10) begin
               k = ($urandom_range(0, 1) == 0) ? $signed($urandom) : key_shadow[idx] + 1;
               store_key($urandom_range(0, DEPTH - 1), k);
            end else if (r < 55)
               lookup_key(key_shadow[idx]);
            else if (r < 75)
               lookup_key(($urandom_range(0, 1) == 0) ? key_shadow[idx] + 1
                                                       : key_shadow[idx] - 1);
            else
               lookup_key($urandom);
            sent++;
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin : result_checker
      lookup_type exp_r;
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         if (pending_lookups.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result beat found=%0b pos=%0d",
                        rsp_chan.found, rsp_chan.match_position);
         end else begin
            exp_r = pending_lookups.pop_front();
            if (rsp_chan.found !== exp_r.found ||
                rsp_chan.match_position !== exp_r.position) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: found exp %0b got %0b, pos exp %0d got %0d",
                           exp_r.found, rsp_chan.found,
                           exp_r.position, rsp_chan.match_position);
            end
         end
         @(negedge clock);
      end
   end

   initial begin : main_sequence
      reset                   = 1'b1;
      csr_wr_en               = 1'b0;
      csr_wr_data             = '0;
      req_chan.valid          = 1'b0;
      req_chan.cmd            = CMD_WRITE;
      req_chan.entry_position = '0;
      req_chan.key_value      = '0;
      for (int i = 0; i < DEPTH; i++) key_shadow[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_sorted_extremes();
      test_entry_counts();
      test_unsorted_keys();
      test_random_lookups();
      settle();
      repeat (20) @(posedge clock);
      if (pending_lookups.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
src/stbs_pkg.sv
src/stbs_req_if.sv
src/stbs_rsp_if.sv
src/stbs_datapath.sv
src/stbs_ctrl.sv
src/sorted_table_binary_search_core.sv
tb/sorted_table_binary_search_core_test.sv
